>>> design/gcrr_pkg.sv
// Shared widths, constants and register codes of the grid cell rotation remap block
package gcrr_pkg;

  // Field and register widths
  localparam int CELL_W  = 8;
  localparam int PIV_W   = 23;
  localparam int TRIG_W  = 16;
  localparam int CS_W    = 10;
  localparam int GRID_W  = 9;
  localparam int CFG_W   = 23;
  localparam int CFG_A_W = 3;

  // Fixed-point formats
  localparam int TRIG_FRAC_BITS = 14;
  localparam int PIV_FRAC_BITS  = 4;
  localparam int MAX_GRID_SIDE  = 256;

  // Reset values of the registers
  localparam logic signed [TRIG_W-1:0] COS_RESET = TRIG_W'(1 << TRIG_FRAC_BITS);
  localparam logic [GRID_W-1:0]        GRID_RESET = GRID_W'(256);

  // Register indexes on the configuration port
  typedef enum logic [CFG_A_W-1:0] {
    REG_PIVOT_X     = 3'd0,
    REG_PIVOT_Y     = 3'd1,
    REG_COS_ANGLE   = 3'd2,
    REG_SIN_ANGLE   = 3'd3,
    REG_ROTATE_EN   = 3'd4,
    REG_CELL_PITCH  = 3'd5,
    REG_GRID_WIDTH  = 3'd6,
    REG_GRID_HEIGHT = 3'd7
  } cfg_reg_e;

endpackage

>>> design/gcrr_if.sv
// Valid/ready channel interfaces for source cells and destination cells
interface gcrr_cell_if;
  logic                       valid;
  logic                       ready;
  logic [gcrr_pkg::CELL_W-1:0] cell_row;
  logic [gcrr_pkg::CELL_W-1:0] cell_col;

  modport source (output valid, output cell_row, output cell_col, input ready);
  modport sink   (input valid, input cell_row, input cell_col, output ready);
endinterface

interface gcrr_dest_if;
  logic                       valid;
  logic                       ready;
  logic [gcrr_pkg::CELL_W-1:0] dest_col;
  logic [gcrr_pkg::CELL_W-1:0] dest_row;
  logic                       dest_valid;

  modport source (output valid, output dest_col, output dest_row, output dest_valid,
                  input ready);
  modport sink   (input valid, input dest_col, input dest_row, input dest_valid,
                  output ready);
endinterface

>>> design/grid_cell_rotation_remap.sv
// Top level: pipelined remap of a grid cell through rotation about a pivot
//
// Usage
//   cell_i  : sink of source cells (cell_row, cell_col), one transaction each.
//   dest_o  : source of mapped cells (dest_col, dest_row, dest_valid), one
//             transaction for every accepted source cell, in order.
//   cfg_*   : write-only register port; write while no transaction is in flight.
//   Stages  : 16 registers lie between the accepted cell and dest_o.valid:
//             six arithmetic stages, nine restoring divider stages (one
//             quotient bit each, divisor twice the cell size), output register.
//   Rate    : one cell per cycle sustained while dest_o.ready stays high; the four
//             16x25 multipliers of the rotation stage and the divider stages all run in parallel.
//   Stall   : every stage holds while the stage after it is full and stalled;
//             empty stages keep filling, so bubbles are squeezed out before
//             cell_i.ready drops.
//   Reset   : rst_ni clears all stage valid bits and loads the registers with
//             identity rotation, cell size 1 and a 256 by 256 grid, translate
//             mode, pivot at the origin.
module grid_cell_rotation_remap #(
  parameter int MAX_GRID_SIDE = gcrr_pkg::MAX_GRID_SIDE
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gcrr_pkg::CFG_A_W-1:0]   cfg_idx_i,
  input  logic [gcrr_pkg::CFG_W-1:0]     cfg_wdata_i,
  gcrr_cell_if.sink                      cell_i,
  gcrr_dest_if.source                    dest_o
);

  localparam int CELL_W = gcrr_pkg::CELL_W;
  localparam int CS_W   = gcrr_pkg::CS_W;
  localparam int PIV_W  = gcrr_pkg::PIV_W;
  localparam int TRIG_W = gcrr_pkg::TRIG_W;
  localparam int GRID_W = gcrr_pkg::GRID_W;
  localparam int POS_W  = CELL_W + CS_W;               // cell index times cell size
  localparam int D_W    = PIV_W + 2;                   // offset from pivot, signed
  localparam int PROD_W = TRIG_W + D_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SH_ROT = gcrr_pkg::PIV_FRAC_BITS + gcrr_pkg::TRIG_FRAC_BITS - 1;
  localparam int SH_TR  = gcrr_pkg::PIV_FRAC_BITS - 1;
  localparam int N_W    = SUM_W - SH_ROT + 1;          // dividend after pre-shift
  localparam int QB     = GRID_W;                      // quotient bits kept
  localparam int DIV_W  = CS_W + 1;                    // divisor 2*cell size
  localparam int REM_W  = DIV_W + QB;
  localparam int NSTG   = 7 + QB;
  localparam int ST_DIV = 6;                           // first divider stage
  localparam int ST_OUT = NSTG - 1;
  localparam int LIM_W  = ($clog2(MAX_GRID_SIDE + 1) > GRID_W) ?
                          $clog2(MAX_GRID_SIDE + 1) : GRID_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [PIV_W-1:0]  pivot_x_q, pivot_y_q;
  logic signed [TRIG_W-1:0] cos_q, sin_q;
  logic                     rotate_q;
  logic [CS_W-1:0]          cell_pitch_q;
  logic [GRID_W-1:0]        grid_width_q, grid_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_x_q     <= '0;
      pivot_y_q     <= '0;
      cos_q         <= gcrr_pkg::COS_RESET;
      sin_q         <= '0;
      rotate_q      <= 1'b0;
      cell_pitch_q  <= CS_W'(1);
      grid_width_q  <= gcrr_pkg::GRID_RESET;
      grid_height_q <= gcrr_pkg::GRID_RESET;
    end else if (cfg_we_i) begin
      unique case (gcrr_pkg::cfg_reg_e'(cfg_idx_i))
        gcrr_pkg::REG_PIVOT_X:     pivot_x_q     <= $signed(cfg_wdata_i[PIV_W-1:0]);
        gcrr_pkg::REG_PIVOT_Y:     pivot_y_q     <= $signed(cfg_wdata_i[PIV_W-1:0]);
        gcrr_pkg::REG_COS_ANGLE:   cos_q         <= $signed(cfg_wdata_i[TRIG_W-1:0]);
        gcrr_pkg::REG_SIN_ANGLE:   sin_q         <= $signed(cfg_wdata_i[TRIG_W-1:0]);
        gcrr_pkg::REG_ROTATE_EN:   rotate_q      <= cfg_wdata_i[0];
        gcrr_pkg::REG_CELL_PITCH:  cell_pitch_q  <= cfg_wdata_i[CS_W-1:0];
        gcrr_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i[GRID_W-1:0];
        gcrr_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_wdata_i[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived settings: zero cell size acts as one, grid limited to the maximum side
  logic [CS_W-1:0]  cs_eff;
  logic [DIV_W-1:0] divisor;
  logic [LIM_W-1:0] w_lim, h_lim;

  assign cs_eff  = (cell_pitch_q == '0) ? CS_W'(1) : cell_pitch_q;
  assign divisor = {cs_eff, 1'b0};
  assign w_lim   = (LIM_W'(grid_width_q) > LIM_W'(MAX_GRID_SIDE)) ?
                   LIM_W'(MAX_GRID_SIDE) : LIM_W'(grid_width_q);
  assign h_lim   = (LIM_W'(grid_height_q) > LIM_W'(MAX_GRID_SIDE)) ?
                   LIM_W'(MAX_GRID_SIDE) : LIM_W'(grid_height_q);

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage moves when it is empty or the next one moves
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] en;
  logic [NSTG-1:0] vld_in;

  always_comb begin
    en[ST_OUT] = !vld_q[ST_OUT] || dest_o.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign vld_in = {vld_q[NSTG-2:0], cell_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) vld_q[k] <= vld_in[k];
      end
    end
  end

  assign cell_i.ready = en[0];

  // ---------------------------------------------------------------------------
  // Stage 1: world position of the cell (index times cell size)
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [CELL_W-1:0] col;
  } s1_t;

  s1_t s1_d, s1_q;

  always_comb begin
    s1_d.pos_x = POS_W'(cell_i.cell_col) * POS_W'(cs_eff);
    s1_d.pos_y = POS_W'(cell_i.cell_row) * POS_W'(cs_eff);
    s1_d.col   = cell_i.cell_col;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) s1_q <= s1_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: offsets from the pivot in Q.4, and the shifted row for translate
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic signed [D_W-1:0] dx;
    logic signed [D_W-1:0] dy;
    logic signed [D_W-1:0] tr;
    logic [CELL_W-1:0]     col;
  } s2_t;

  s2_t s2_d, s2_q;
  logic signed [D_W-1:0] wx, wy;

  always_comb begin
    wx = D_W'($signed({1'b0, s1_q.pos_x, {gcrr_pkg::PIV_FRAC_BITS{1'b0}}}));
    wy = D_W'($signed({1'b0, s1_q.pos_y, {gcrr_pkg::PIV_FRAC_BITS{1'b0}}}));
    s2_d.dx  = wx - D_W'(pivot_x_q);
    s2_d.dy  = wy - D_W'(pivot_y_q);
    s2_d.tr  = wy + D_W'(pivot_y_q);
    s2_d.col = s1_q.col;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) s2_q <= s2_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: the four rotation products
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic signed [PROD_W-1:0] cdx;
    logic signed [PROD_W-1:0] sdy;
    logic signed [PROD_W-1:0] sdx;
    logic signed [PROD_W-1:0] cdy;
    logic signed [D_W-1:0]    tr;
    logic [CELL_W-1:0]        col;
  } s3_t;

  s3_t s3_d, s3_q;

  always_comb begin
    s3_d.cdx = PROD_W'(cos_q) * PROD_W'(s2_q.dx);
    s3_d.sdy = PROD_W'(sin_q) * PROD_W'(s2_q.dy);
    s3_d.sdx = PROD_W'(sin_q) * PROD_W'(s2_q.dx);
    s3_d.cdy = PROD_W'(cos_q) * PROD_W'(s2_q.dy);
    s3_d.tr  = s2_q.tr;
    s3_d.col = s2_q.col;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) s3_q <= s3_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: rotated position, pivot added back, Q.(4+14)
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [D_W-1:0]   tr;
    logic [CELL_W-1:0]       col;
  } s4_t;

  s4_t s4_d, s4_q;

  always_comb begin
    s4_d.sx  = (SUM_W'(pivot_x_q) <<< gcrr_pkg::TRIG_FRAC_BITS)
             + SUM_W'(s3_q.cdx) - SUM_W'(s3_q.sdy);
    s4_d.sy  = (SUM_W'(pivot_y_q) <<< gcrr_pkg::TRIG_FRAC_BITS)
             + SUM_W'(s3_q.sdx) + SUM_W'(s3_q.cdy);
    s4_d.tr  = s3_q.tr;
    s4_d.col = s3_q.col;
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) s4_q <= s4_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: magnitude, pre-shift by half the scale, add cell size for rounding.
  // round(m / (2^k * cs)) = floor(((m >> (k-1)) + cs) / (2*cs))
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [N_W-1:0]    nx;
    logic [N_W-1:0]    ny;
    logic              neg_x;
    logic              neg_y;
    logic [CELL_W-1:0] col;
  } s5_t;

  s5_t s5_d, s5_q;
  logic [SUM_W-1:0] mag_x, mag_y;
  logic [D_W-1:0]   mag_t;

  always_comb begin
    mag_x = s4_q.sx[SUM_W-1] ? SUM_W'(-s4_q.sx) : SUM_W'(s4_q.sx);
    mag_y = s4_q.sy[SUM_W-1] ? SUM_W'(-s4_q.sy) : SUM_W'(s4_q.sy);
    mag_t = s4_q.tr[D_W-1]   ? D_W'(-s4_q.tr)   : D_W'(s4_q.tr);
    s5_d.nx    = N_W'(mag_x >> SH_ROT) + N_W'(cs_eff);
    s5_d.neg_x = s4_q.sx[SUM_W-1];
    if (rotate_q) begin
      s5_d.ny    = N_W'(mag_y >> SH_ROT) + N_W'(cs_eff);
      s5_d.neg_y = s4_q.sy[SUM_W-1];
    end else begin
      s5_d.ny    = N_W'(mag_t >> SH_TR) + N_W'(cs_eff);
      s5_d.neg_y = s4_q.tr[D_W-1];
    end
    s5_d.col = s4_q.col;
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) s5_q <= s5_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 6: quotient overflow check, then nine restoring divider stages
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [REM_W-1:0]  rem_x;
    logic [REM_W-1:0]  rem_y;
    logic [QB-1:0]     q_x;
    logic [QB-1:0]     q_y;
    logic              ovf_x;
    logic              ovf_y;
    logic              neg_x;
    logic              neg_y;
    logic [CELL_W-1:0] col;
  } div_t;

  div_t div_q [0:QB];
  div_t div0_d;
  logic [N_W-1:0] ovf_lim;

  always_comb begin
    ovf_lim      = N_W'({divisor, {QB{1'b0}}});
    div0_d.rem_x = s5_q.nx[REM_W-1:0];
    div0_d.rem_y = s5_q.ny[REM_W-1:0];
    div0_d.q_x   = '0;
    div0_d.q_y   = '0;
    div0_d.ovf_x = (s5_q.nx >= ovf_lim);
    div0_d.ovf_y = (s5_q.ny >= ovf_lim);
    div0_d.neg_x = s5_q.neg_x;
    div0_d.neg_y = s5_q.neg_y;
    div0_d.col   = s5_q.col;
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) div_q[0] <= div0_d;
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int BIT = QB - 1 - k;
    div_t             nxt;
    logic [REM_W-1:0] dsh;

    // One quotient bit per stage for both coordinates
    always_comb begin
      dsh = REM_W'(divisor) << BIT;
      nxt = div_q[k];
      if (div_q[k].rem_x >= dsh) begin
        nxt.rem_x    = div_q[k].rem_x - dsh;
        nxt.q_x[BIT] = 1'b1;
      end
      if (div_q[k].rem_y >= dsh) begin
        nxt.rem_y    = div_q[k].rem_y - dsh;
        nxt.q_y[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[ST_DIV+k]) div_q[k+1] <= nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: bounds check, zero the coordinates when outside the grid
  // ---------------------------------------------------------------------------
  logic [CELL_W-1:0] col_d, row_d, col_q, row_q;
  logic              ok_d, ok_q, ok_x, ok_y;
  logic [QB-1:0]     fx;

  always_comb begin
    if (rotate_q) begin
      fx   = div_q[QB].q_x;
      ok_x = !div_q[QB].ovf_x && (!div_q[QB].neg_x || div_q[QB].q_x == '0) &&
             (LIM_W'(div_q[QB].q_x) < w_lim);
    end else begin
      fx   = QB'(div_q[QB].col);
      ok_x = (LIM_W'(div_q[QB].col) < w_lim);
    end
    ok_y  = !div_q[QB].ovf_y && (!div_q[QB].neg_y || div_q[QB].q_y == '0) &&
            (LIM_W'(div_q[QB].q_y) < h_lim);
    ok_d  = ok_x && ok_y;
    col_d = ok_d ? fx[CELL_W-1:0] : '0;
    row_d = ok_d ? div_q[QB].q_y[CELL_W-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      col_q <= col_d;
      row_q <= row_d;
      ok_q  <= ok_d;
    end
  end

  assign dest_o.valid      = vld_q[ST_OUT];
  assign dest_o.dest_col   = col_q;
  assign dest_o.dest_row   = row_q;
  assign dest_o.dest_valid = ok_q;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the grid cell rotation remap block
`timescale 1ns / 1ps

module testbench;
  import gcrr_pkg::*;

  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 96;

  typedef struct packed {
    logic [CELL_W-1:0] row;
    logic [CELL_W-1:0] col;
  } cell_t;

  typedef struct packed {
    logic [CELL_W-1:0] dest_col;
    logic [CELL_W-1:0] dest_row;
    logic              dest_valid;
  } dest_t;

  logic clk;
  logic rst_n = 1'b0;

  // Configuration port
  logic               cfg_we    = 1'b0;
  logic [CFG_A_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  // Channel drive, known from time zero
  logic              src_valid = 1'b0;
  logic [CELL_W-1:0] src_row   = '0;
  logic [CELL_W-1:0] src_col   = '0;
  logic              snk_ready = 1'b0;

  gcrr_cell_if cells ();
  gcrr_dest_if dests ();

  assign cells.valid    = src_valid;
  assign cells.cell_row = src_row;
  assign cells.cell_col = src_col;
  assign dests.ready    = snk_ready;

  grid_cell_rotation_remap dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .cell_i      (cells),
    .dest_o      (dests)
  );

  // Shadow copy of the register file
  logic signed [PIV_W-1:0]  shd_piv_x = '0;
  logic signed [PIV_W-1:0]  shd_piv_y = '0;
  logic signed [TRIG_W-1:0] shd_cos   = COS_RESET;
  logic signed [TRIG_W-1:0] shd_sin   = '0;
  logic                     shd_rot   = 1'b0;
  logic [CS_W-1:0]          shd_cs    = CS_W'(1);
  logic [GRID_W-1:0]        shd_w     = GRID_RESET;
  logic [GRID_W-1:0]        shd_h     = GRID_RESET;

  cell_t cells_to_send[$];
  dest_t expected_dest[$];

  int  errors        = 0;
  int  cells_checked = 0;
  int  settings_used = 1;
  int  cycles        = 0;
  int  src_idle_pct  = 0;
  int  snk_idle_pct  = 0;
  int  src_gap       = 0;
  int  snk_gap       = 0;
  int  hold_left     = 0;
  bit  hold_req      = 1'b0;
  bit  hold_done     = 1'b0;
  bit  no_idle       = 1'b0;

  // Divide, rounding half away from zero
  function automatic longint round_half_away(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q   = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  // Expected destination cell under the current register settings
  function automatic dest_t remap_cell(cell_t c);
    longint cs, w, h, one, px, py, cosv, sinv, dx, dy, sx, sy, nx, ny;
    dest_t  d;
    cs   = (shd_cs == 0) ? 64'sd1 : longint'(shd_cs);
    w    = (shd_w > MAX_GRID_SIDE) ? longint'(MAX_GRID_SIDE) : longint'(shd_w);
    h    = (shd_h > MAX_GRID_SIDE) ? longint'(MAX_GRID_SIDE) : longint'(shd_h);
    px   = longint'(shd_piv_x);
    py   = longint'(shd_piv_y);
    cosv = longint'(shd_cos);
    sinv = longint'(shd_sin);
    if (shd_rot) begin
      one = longint'(1) << TRIG_FRAC_BITS;
      dx  = longint'(c.col) * cs * 16 - px;
      dy  = longint'(c.row) * cs * 16 - py;
      sx  = px * one + cosv * dx - sinv * dy;
      sy  = py * one + sinv * dx + cosv * dy;
      nx  = round_half_away(sx, cs * 16 * one);
      ny  = round_half_away(sy, cs * 16 * one);
    end else begin
      nx = longint'(c.col);
      ny = round_half_away(longint'(c.row) * cs * 16 + py, cs * 16);
    end
    if (nx >= 0 && nx < w && ny >= 0 && ny < h) begin
      d.dest_col   = nx[CELL_W-1:0];
      d.dest_row   = ny[CELL_W-1:0];
      d.dest_valid = 1'b1;
    end else begin
      d = '0;
    end
    return d;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cell driver: predicts each accepted transaction, then offers the next cell
  always @(posedge clk or negedge rst_n) begin : cell_driver
    cell_t nxt;
    if (!rst_n) begin
      src_valid <= 1'b0;
      src_row   <= '0;
      src_col   <= '0;
    end else if (!src_valid || cells.ready) begin
      if (src_valid) begin
        expected_dest.push_back(remap_cell('{row: src_row, col: src_col}));
      end
      if (src_gap > 0) begin
        src_gap--;
        src_valid <= 1'b0;
      end else if (!no_idle && hold_left == 0 && src_idle_pct > 0 &&
                   $urandom_range(0, 99) < src_idle_pct) begin
        src_gap = $urandom_range(0, 10);
        src_valid <= 1'b0;
      end else if (cells_to_send.size() > 0) begin
        nxt = cells_to_send.pop_front();
        src_valid <= 1'b1;
        src_row   <= nxt.row;
        src_col   <= nxt.col;
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // Result ready: random stall bursts plus one long hold-off
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      snk_ready <= 1'b0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        snk_ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        snk_ready <= 1'b0;
      end else if (!no_idle && snk_idle_pct > 0 && $urandom_range(0, 99) < snk_idle_pct) begin
        snk_gap = $urandom_range(0, 10);
        snk_ready <= 1'b0;
      end else begin
        snk_ready <= 1'b1;
      end
    end
  end

  task automatic report_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // Result monitor: compare each transaction with the oldest prediction
  always @(posedge clk) begin : dest_monitor
    dest_t want;
    if (rst_n && dests.valid && dests.ready) begin
      if (expected_dest.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual col %0d row %0d valid %0b",
                 $time, dests.dest_col, dests.dest_row, dests.dest_valid);
        errors++;
      end else begin
        want = expected_dest.pop_front();
        report_field("dest_col", want.dest_col, dests.dest_col);
        report_field("dest_row", want.dest_row, dests.dest_row);
        report_field("dest_valid", want.dest_valid, dests.dest_valid);
        cells_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               expected_dest.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Register write, mirrored into the shadow copy
  task automatic write_reg(cfg_reg_e idx, int value);
    logic [CFG_W-1:0] v;
    v = CFG_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_PIVOT_X:     shd_piv_x = v[PIV_W-1:0];
      REG_PIVOT_Y:     shd_piv_y = v[PIV_W-1:0];
      REG_COS_ANGLE:   shd_cos   = v[TRIG_W-1:0];
      REG_SIN_ANGLE:   shd_sin   = v[TRIG_W-1:0];
      REG_ROTATE_EN:   shd_rot   = v[0];
      REG_CELL_PITCH:  shd_cs    = v[CS_W-1:0];
      REG_GRID_WIDTH:  shd_w     = v[GRID_W-1:0];
      REG_GRID_HEIGHT: shd_h     = v[GRID_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(int px, int py, int c, int s, int rot, int cs, int w, int h);
    write_reg(REG_PIVOT_X, px);
    write_reg(REG_PIVOT_Y, py);
    write_reg(REG_COS_ANGLE, c);
    write_reg(REG_SIN_ANGLE, s);
    write_reg(REG_ROTATE_EN, rot);
    write_reg(REG_CELL_PITCH, cs);
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic queue_cell(int row, int col);
    cells_to_send.push_back('{row: CELL_W'(row), col: CELL_W'(col)});
  endtask

  // Wait until every cell is sent and every result checked, then let the pipe settle
  task automatic drain();
    do @(negedge clk);
    while (cells_to_send.size() != 0 || src_valid || expected_dest.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Random settings, mostly a pivot inside the grid and small cells
  task automatic randomise_config();
    int  cs, cs_eff, w, h, w_eff, h_eff, c, s, px, py, rot;
    real th;
    case ($urandom_range(0, 19))
      0:       cs = 0;
      1:       cs = 1023;
      2, 3, 4: cs = $urandom_range(9, 1023);
      default: cs = $urandom_range(1, 8);
    endcase
    case ($urandom_range(0, 15))
      0:       w = 0;
      1:       w = $urandom_range(257, 511);
      2:       w = 256;
      default: w = $urandom_range(1, 256);
    endcase
    case ($urandom_range(0, 15))
      0:       h = 0;
      1:       h = $urandom_range(257, 511);
      2:       h = 256;
      default: h = $urandom_range(1, 256);
    endcase
    cs_eff = (cs == 0) ? 1 : cs;
    w_eff  = (w > MAX_GRID_SIDE) ? MAX_GRID_SIDE : w;
    h_eff  = (h > MAX_GRID_SIDE) ? MAX_GRID_SIDE : h;
    rot    = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 7) != 0) begin
      th = real'($urandom_range(0, 3599)) * 3.14159265358979 / 1800.0;
      c  = int'(16384.0 * $cos(th));
      s  = int'(16384.0 * $sin(th));
    end else begin
      c = int'($urandom_range(0, 65535)) - 32768;
      s = int'($urandom_range(0, 65535)) - 32768;
    end
    if ($urandom_range(0, 4) != 0) begin
      px = int'($urandom_range(0, w_eff)) * cs_eff * 16 + int'($urandom_range(0, 15));
      if (rot)
        py = int'($urandom_range(0, h_eff)) * cs_eff * 16 + int'($urandom_range(0, 15));
      else
        py = (int'($urandom_range(0, 40)) - 20) * cs_eff * 16 + int'($urandom_range(0, 15));
    end else begin
      px = int'($urandom_range(0, 8388607)) - 4194304;
      py = int'($urandom_range(0, 8388607)) - 4194304;
    end
    apply_config(px, py, c, s, rot, cs, w, h);
  endtask

  task automatic queue_random_cells(int n);
    int w_eff, h_eff;
    w_eff = (shd_w > MAX_GRID_SIDE) ? MAX_GRID_SIDE : int'(shd_w);
    h_eff = (shd_h > MAX_GRID_SIDE) ? MAX_GRID_SIDE : int'(shd_h);
    repeat (n) begin
      if (w_eff > 0 && h_eff > 0 && $urandom_range(0, 99) < 85)
        queue_cell($urandom_range(0, h_eff - 1), $urandom_range(0, w_eff - 1));
      else
        queue_cell($urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  task automatic pick_idle_rates();
    case ($urandom_range(0, 3))
      0:       src_idle_pct = 0;
      1:       src_idle_pct = 5;
      2:       src_idle_pct = 20;
      default: src_idle_pct = 45;
    endcase
    case ($urandom_range(0, 3))
      0:       snk_idle_pct = 0;
      1:       snk_idle_pct = 5;
      2:       snk_idle_pct = 20;
      default: snk_idle_pct = 45;
    endcase
  endtask

  // Stimulus sequence
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    pick_idle_rates();

    // Reset settings: identity map, corners of the grid
    queue_cell(0, 0);
    queue_cell(255, 255);
    queue_cell(0, 255);
    queue_cell(255, 0);
    drain();

    // Translate by exactly half a cell: ties round away from zero
    apply_config(0, 8, 16384, 0, 0, 1, 256, 256);
    queue_cell(5, 3);
    queue_cell(255, 7);
    drain();
    apply_config(0, -8, 16384, 0, 0, 1, 256, 256);
    queue_cell(0, 9);
    queue_cell(5, 200);
    drain();

    // Zero cell size counts as one; oversized grid clamps to the maximum
    apply_config(0, -16, 16384, 0, 0, 0, 511, 300);
    queue_cell(0, 0);
    queue_cell(255, 128);
    queue_cell(1, 255);
    drain();

    // Largest cell size and pivot extremes in translate mode
    apply_config(-4194304, 4194303, 16384, 0, 0, 1023, 256, 256);
    queue_cell(0, 0);
    queue_cell(255, 255);
    drain();

    // Identity rotation
    apply_config(0, 0, 16384, 0, 1, 1, 256, 256);
    queue_cell(0, 0);
    queue_cell(255, 255);
    queue_cell(17, 200);
    drain();

    // Quarter turn about the grid centre
    apply_config(8192, 8192, 0, 16384, 1, 4, 256, 256);
    queue_cell(0, 0);
    queue_cell(255, 10);
    queue_cell(100, 200);
    drain();

    // Trig beyond unit range, pivots at the extremes, one-cell grid
    apply_config(4194303, -4194304, -32768, 32767, 1, 1023, 1, 1);
    queue_cell(0, 0);
    queue_cell(255, 255);
    drain();

    // Empty grid: every destination invalid
    apply_config(0, 0, 16384, 0, 1, 1, 0, 0);
    queue_cell(0, 0);
    queue_cell(3, 3);
    drain();

    // Source cell outside the grid is still mapped
    apply_config(0, -190 * 16, 16384, 0, 0, 1, 16, 16);
    queue_cell(200, 5);
    queue_cell(20, 3);
    drain();

    // Random settings and cells
    for (int p = 0; p < 10; p++) begin
      randomise_config();
      pick_idle_rates();
      if (p == 4) begin
        queue_random_cells(120);
        hold_req = 1'b1;
      end else begin
        queue_random_cells(60);
      end
      drain();
    end

    // Closing stretch at full rate
    no_idle = 1'b1;
    randomise_config();
    queue_random_cells(40);
    drain();

    $display("Remapped and checked %0d cells under %0d register settings", cells_checked,
             settings_used);
    $display("Covered rotate and translate modes, empty and oversized grids,");
    $display("extreme pivots, trig values and cell sizes");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
